>>> src/assert_macros.svh
// Assertion macros shared by the epoch-to-calendar RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Invariant checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("%m: invariant check failed");

`endif

>>> src/esc_pkg.sv
// Types, constants, microcode and calendar helpers for the epoch-to-calendar block.
`default_nettype none
package esc_pkg;

    localparam int SECS_W  = 32;
    localparam int BASE_W  = 12;
    localparam int YEAR_W  = 13;
    localparam int DAYS_W  = 16;
    localparam int TOD_W   = 17;
    localparam int Y400_W  = 9;
    localparam int PC_W    = 4;
    localparam int CNT_W   = 6;
    localparam int OUT_W   = 40;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_DIV,
        OP_LOAD_BASE,
        OP_LOAD_TOD,
        OP_LOAD_MS,
        OP_SAVE_MS,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN,
        DIV_400
    } t_div_sel;

    typedef struct packed {
        t_op               op;
        t_div_sel          div_sel;
        logic [CNT_W-1:0]  count;
        logic [PC_W-1:0]   next;
    } t_cw;

    typedef struct packed {
        logic accept;
        logic year_fit;
        logic month_stop;
        logic out_free;
    } t_seq_status;

    localparam logic [PC_W-1:0] PC_WAIT     = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV_DAY  = 4'd1;
    localparam logic [PC_W-1:0] PC_BASE     = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV_400  = 4'd3;
    localparam logic [PC_W-1:0] PC_TOD      = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV_HOUR = 4'd5;
    localparam logic [PC_W-1:0] PC_MS       = 4'd6;
    localparam logic [PC_W-1:0] PC_DIV_MIN  = 4'd7;
    localparam logic [PC_W-1:0] PC_SAVE     = 4'd8;
    localparam logic [PC_W-1:0] PC_YEAR     = 4'd9;
    localparam logic [PC_W-1:0] PC_MONTH    = 4'd10;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd11;
    localparam logic [PC_W-1:0] PC_LAST     = PC_EMIT;

    localparam logic [BASE_W-1:0] BASE_YEAR_RESET = 12'd2000;

    // The control store. A divide word stays until its preloaded count runs
    // down; the other words leave to next once their condition holds.
    function automatic t_cw ucode(input logic [PC_W-1:0] pc);
        t_cw cw;
        cw = '{op: OP_WAIT, div_sel: DIV_DAY, count: '0, next: PC_WAIT};
        unique case (pc)
            PC_WAIT:     cw = '{OP_WAIT,      DIV_DAY,  CNT_W'(0),  PC_DIV_DAY};
            PC_DIV_DAY:  cw = '{OP_DIV,       DIV_DAY,  CNT_W'(2),  PC_BASE};
            PC_BASE:     cw = '{OP_LOAD_BASE, DIV_DAY,  CNT_W'(0),  PC_DIV_400};
            PC_DIV_400:  cw = '{OP_DIV,       DIV_400,  CNT_W'(2),  PC_TOD};
            PC_TOD:      cw = '{OP_LOAD_TOD,  DIV_DAY,  CNT_W'(0),  PC_DIV_HOUR};
            PC_DIV_HOUR: cw = '{OP_DIV,       DIV_HOUR, CNT_W'(2),  PC_MS};
            PC_MS:       cw = '{OP_LOAD_MS,   DIV_DAY,  CNT_W'(0),  PC_DIV_MIN};
            PC_DIV_MIN:  cw = '{OP_DIV,       DIV_MIN,  CNT_W'(2),  PC_SAVE};
            PC_SAVE:     cw = '{OP_SAVE_MS,   DIV_DAY,  CNT_W'(0),  PC_YEAR};
            PC_YEAR:     cw = '{OP_YEAR,      DIV_DAY,  CNT_W'(0),  PC_MONTH};
            PC_MONTH:    cw = '{OP_MONTH,     DIV_DAY,  CNT_W'(0),  PC_EMIT};
            PC_EMIT:     cw = '{OP_EMIT,      DIV_DAY,  CNT_W'(0),  PC_WAIT};
            default:     cw = '{OP_WAIT,      DIV_DAY,  CNT_W'(0),  PC_DIV_DAY};
        endcase
        return cw;
    endfunction

    function automatic logic [TOD_W-1:0] divisor(input t_div_sel sel);
        logic [TOD_W-1:0] d;
        unique case (sel)
            DIV_DAY:  d = 17'd86400;
            DIV_HOUR: d = 17'd3600;
            DIV_MIN:  d = 17'd60;
            DIV_400:  d = 17'd400;
            default:  d = 17'd86400;
        endcase
        return d;
    endfunction

    // Quotient by multiplication with a rounded-up reciprocal, exact over the
    // dividend range of each step. The day split drops the factor 128 first
    // so that its reciprocal of 675 stays within 26 bits.
    function automatic logic [DAYS_W-1:0] quotient(input logic [SECS_W-1:0] x,
                                                   input t_div_sel sel);
        logic [50:0]       p_day;
        logic [34:0]       p_hour;
        logic [24:0]       p_min;
        logic [24:0]       p_400;
        logic [DAYS_W-1:0] q;
        p_day  = {26'd0, x[31:7]} * 51'd50903317;
        p_hour = {18'd0, x[16:0]} * 35'd149131;
        p_min  = {13'd0, x[11:0]} * 25'd4370;
        p_400  = {13'd0, x[11:0]} * 25'd5243;
        unique case (sel)
            DIV_DAY:  q = p_day[50:35];
            DIV_HOUR: q = {10'd0, p_hour[34:29]};
            DIV_MIN:  q = {9'd0, p_min[24:18]};
            DIV_400:  q = {12'd0, p_400[24:21]};
            default:  q = p_day[50:35];
        endcase
        return q;
    endfunction

    // Leap test from the year modulo 400.
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        return (y400[1:0] == 2'd0)
            && !((y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300));
    endfunction

    // Month index 0 is January.
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [3:0] mm;
        logic [4:0] len;
        mm = (m > 4'd6) ? m - 4'd1 : m;
        if (m == 4'd1) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = mm[0] ? 5'd30 : 5'd31;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

>>> src/epoch_seconds_to_calendar_top.sv
// Top level: epoch seconds to calendar date and time, microcoded datapath.
// One transaction in gives one transaction out. A conversion runs through a
// microcode program that drives a small datapath. Division by the constants
// 86400, 3600, 60 and 400 uses reciprocal multiplication, and each divide word
// first registers the quotient and then the remainder, which is reckoned from
// the registered quotient. The year loop then steps over one elapsed year at a
// time, at most 136 years past base_year, and the month loop over one elapsed
// month at a time, up to the month index (0 to 11). A new item can be accepted
// in the cycle after the previous result is loaded, while that result still
// waits in the output register; if that register is still full when the next
// result is done, the program holds in its last step and the input waits.
// base_year is written through i_cfg_we and i_cfg_wdata and resets to 2000;
// the user must write it only while the block is idle, which the block itself
// does not enforce.
`default_nettype none
`include "assert_macros.svh"
module epoch_seconds_to_calendar_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [11:0] i_cfg_wdata,     // base_year
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,    // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    output logic [39:0] m_axis_tdata
);
    import esc_pkg::*;

    t_cw         cw;
    t_seq_status status;

    logic [BASE_W-1:0] r_base;
    logic [SECS_W-1:0] r_num, n_num;
    logic [DAYS_W-1:0] r_quo, n_quo;
    logic [TOD_W-1:0]  r_rem, n_rem;
    logic [DAYS_W-1:0] r_days, n_days;
    logic [TOD_W-1:0]  r_tod, n_tod;
    logic [Y400_W-1:0] r_y400, n_y400;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [3:0]        r_month, n_month;
    logic [4:0]        r_hour, n_hour;
    logic [5:0]        r_min, n_min;
    logic [5:0]        r_sec, n_sec;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out_data, n_out_data;

    logic [TOD_W-1:0]        dv;
    logic [DAYS_W-1:0]       quo;
    logic [DAYS_W+TOD_W-1:0] prod;
    logic [SECS_W-1:0]       rem_full;
    logic                    leap;
    logic [8:0]              ylen;
    logic [4:0]              mlen;
    logic                    out_load;
    logic [4:0]              day_out;

    esc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cw     (cw)
    );

    // Divider and loop conditions. The remainder uses the quotient registered
    // in the previous cycle, so it is valid once that quotient is in r_quo.
    always_comb begin
        dv       = divisor(cw.div_sel);
        quo      = quotient(r_num, cw.div_sel);
        prod     = r_quo * dv;
        rem_full = r_num - prod[SECS_W-1:0];
        leap     = is_leap(r_y400);
        ylen     = leap ? 9'd366 : 9'd365;
        mlen     = month_len(leap, r_month);
        day_out  = r_days[4:0] + 5'd1;

        s_axis_tready     = (cw.op == OP_WAIT);
        status.accept     = s_axis_tvalid;
        status.year_fit   = (r_days < {7'd0, ylen});
        status.month_stop = (r_days < {11'd0, mlen}) || (r_month == 4'd11);
        status.out_free   = !r_out_valid || m_axis_tready;
        out_load          = (cw.op == OP_EMIT) && status.out_free;
    end

    always_comb begin
        n_num   = r_num;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_days  = r_days;
        n_tod   = r_tod;
        n_y400  = r_y400;
        n_year  = r_year;
        n_month = r_month;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        case (cw.op)
            OP_WAIT: begin
                if (s_axis_tvalid) begin
                    n_num = s_axis_tdata;
                end
            end
            OP_DIV: begin
                n_quo = quo;
                n_rem = rem_full[TOD_W-1:0];
            end
            OP_LOAD_BASE: begin
                n_days = r_quo;
                n_tod  = r_rem;
                n_num  = {20'd0, r_base};
                n_year = {1'b0, r_base};
            end
            OP_LOAD_TOD: begin
                n_y400 = r_rem[Y400_W-1:0];
                n_num  = {15'd0, r_tod};
            end
            OP_LOAD_MS: begin
                n_hour = r_quo[4:0];
                n_num  = {20'd0, r_rem[11:0]};
            end
            OP_SAVE_MS: begin
                n_min   = r_quo[5:0];
                n_sec   = r_rem[5:0];
                n_month = '0;
            end
            OP_YEAR: begin
                if (!status.year_fit) begin
                    n_days = r_days - {7'd0, ylen};
                    n_year = r_year + YEAR_W'(1);
                    n_y400 = (r_y400 == 9'd399) ? '0 : r_y400 + 9'd1;
                end
            end
            OP_MONTH: begin
                if (!status.month_stop) begin
                    n_days  = r_days - {11'd0, mlen};
                    n_month = r_month + 4'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: a finished result waits here while the next item runs.
    always_comb begin
        n_out_data = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {2'b00, r_sec, r_min, r_hour, day_out,
                           r_month + 4'd1, r_year[BASE_W-1:0]};
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_YEAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num      <= n_num;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_days     <= n_days;
        r_tod      <= n_tod;
        r_y400     <= n_y400;
        r_year     <= n_year;
        r_month    <= n_month;
        r_hour     <= n_hour;
        r_min      <= n_min;
        r_sec      <= n_sec;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_IMPLY(a_y400_range, i_clk, i_rst_n, cw.op == OP_YEAR, r_y400 < 9'd400)
    `ASSERT_IMPLY(a_month_range, i_clk, i_rst_n, cw.op == OP_MONTH, r_month <= 4'd11)

endmodule
`default_nettype wire

>>> src/esc_seq.sv
// Microcode sequencer: step counter, loop counter and control store.
`default_nettype none
`include "assert_macros.svh"
module esc_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  esc_pkg::t_seq_status i_status,
    output esc_pkg::t_cw        o_cw
);
    import esc_pkg::*;

    logic [PC_W-1:0]  r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_cw              cw;
    t_cw              next_cw;
    logic             advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_WAIT;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    // Next step.
    always_comb begin
        unique case (cw.op)
            OP_WAIT:  advance = i_status.accept;
            OP_DIV:   advance = (r_cnt == CNT_W'(1));
            OP_YEAR:  advance = i_status.year_fit;
            OP_MONTH: advance = i_status.month_stop;
            OP_EMIT:  advance = i_status.out_free;
            default:  advance = 1'b1;
        endcase
        n_pc    = advance ? cw.next : r_pc;
        next_cw = ucode(cw.next);
        // The loop count of the following word is preloaded on the way in.
        if (advance) begin
            n_cnt = next_cw.count;
        end else if (cw.op == OP_DIV) begin
            n_cnt = r_cnt - CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    // Control outputs.
    always_comb begin
        cw   = ucode(r_pc);
        o_cw = cw;
    end

    `ASSERT_IMPLY(a_div_count_live, i_clk, i_rst_n, cw.op == OP_DIV, r_cnt != '0)
    `ASSERT_ALWAYS(a_pc_in_store, i_clk, i_rst_n, r_pc <= PC_LAST)

endmodule
`default_nettype wire
